// ===== rtl/core/voxel_grid_box_sphere_editor_top_assert.svh =====
// assertion helpers for the voxel editor, sampled on clk_i, off while rst_ni is low
`ifndef VOXEL_GRID_BOX_SPHERE_EDITOR_TOP_ASSERT_SVH
`define VOXEL_GRID_BOX_SPHERE_EDITOR_TOP_ASSERT_SVH

// same-cycle implication
`define VGBSE_ASSERT_IMP(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("voxel editor check failed");

// next-cycle implication
`define VGBSE_ASSERT_NXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("voxel editor check failed");

`endif

// ===== rtl/core/vgbse_pkg.sv =====
package vgbse_pkg;

  localparam int unsigned SizeW    = 5;
  localparam int unsigned ChanW    = 8;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned ColW     = 4 * ChanW;
  localparam int unsigned RadSqW   = 16;
  localparam int unsigned SumW     = 18;

  typedef enum logic [2:0] {
    KIND_SET_VOXEL  = 3'd0,
    KIND_CLR_VOXEL  = 3'd1,
    KIND_SET_BOX    = 3'd2,
    KIND_CLR_BOX    = 3'd3,
    KIND_SET_SPHERE = 3'd4,
    KIND_CLR_SPHERE = 3'd5,
    KIND_READ_VOXEL = 3'd6
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SIZE_X  = 3'd0,
    CFG_SIZE_Y  = 3'd1,
    CFG_SIZE_Z  = 3'd2,
    CFG_PAINT_R = 3'd3,
    CFG_PAINT_G = 3'd4,
    CFG_PAINT_B = 3'd5,
    CFG_PAINT_A = 3'd6
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_POINT,
    ST_SWEEP,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic [2:0]        kind;
    logic signed [7:0] x_lo;
    logic signed [7:0] x_hi;
    logic signed [7:0] y_lo;
    logic signed [7:0] y_hi;
    logic signed [7:0] z_lo;
    logic signed [7:0] z_hi;
    logic [7:0]        radius;
  } in_item_t;

  typedef struct packed {
    logic             voxel_on;
    logic [ChanW-1:0] voxel_red;
    logic [ChanW-1:0] voxel_green;
    logic [ChanW-1:0] voxel_blue;
    logic [ChanW-1:0] voxel_alpha;
  } out_item_t;

  // region description handed to the sweep unit
  typedef struct packed {
    logic              sphere;
    logic signed [7:0] x_lo;
    logic signed [7:0] x_hi;
    logic signed [7:0] y_lo;
    logic signed [7:0] y_hi;
    logic signed [7:0] z_lo;
    logic signed [7:0] z_hi;
    logic [RadSqW-1:0] rad_sq;
  } sweep_job_t;

  typedef struct packed {
    logic wr_en;
    logic done;
  } sweep_stat_t;

  // sign-extend a coordinate by one bit
  function automatic logic signed [8:0] sx9(logic signed [7:0] v);
    return {v[7], v};
  endfunction

endpackage

// ===== rtl/core/vgbse_ram.sv =====
module vgbse_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/vgbse_sweep.sv =====
module vgbse_sweep #(
  parameter int unsigned CW = 4,
  parameter int unsigned EW = 5
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  vgbse_pkg::sweep_job_t  job_i,
  input  logic [EW-1:0]          ext_x_i,
  input  logic [EW-1:0]          ext_y_i,
  input  logic [EW-1:0]          ext_z_i,
  output logic [3*CW-1:0]        addr_o,
  output vgbse_pkg::sweep_stat_t stat_o
);

  logic          run_q, run_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic          x_last, y_last, z_last;

  logic signed [8:0]  cx, cy, cz, dx, dy, dz;
  logic signed [17:0] px, py, pz;
  logic               in_box;

  logic                          s1_valid_q;
  logic [3*CW-1:0]               s1_addr_q;
  logic                          s1_box_q;
  logic [vgbse_pkg::RadSqW-1:0]  sq_x_q, sq_y_q, sq_z_q;
  logic [vgbse_pkg::SumW-1:0]    dist_sq;
  logic                          hit;

  assign x_last = (EW'(i_q) + EW'(1)) == ext_x_i;
  assign y_last = (EW'(j_q) + EW'(1)) == ext_y_i;
  assign z_last = (EW'(k_q) + EW'(1)) == ext_z_i;

  // x innermost, then y, then z
  always_comb begin
    run_d = run_q;
    i_d   = i_q;
    j_d   = j_q;
    k_d   = k_q;
    if (start_i) begin
      run_d = 1'b1;
      i_d   = '0;
      j_d   = '0;
      k_d   = '0;
    end else if (run_q) begin
      if (!x_last) begin
        i_d = i_q + CW'(1);
      end else begin
        i_d = '0;
        if (!y_last) begin
          j_d = j_q + CW'(1);
        end else begin
          j_d = '0;
          if (!z_last) begin
            k_d = k_q + CW'(1);
          end else begin
            k_d   = '0;
            run_d = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q      <= 1'b0;
      i_q        <= '0;
      j_q        <= '0;
      k_q        <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      run_q      <= run_d;
      i_q        <= i_d;
      j_q        <= j_d;
      k_q        <= k_d;
      s1_valid_q <= run_q;
    end
  end

  // stage 1: box test and per-axis squared distance
  assign cx = $signed(9'(i_q));
  assign cy = $signed(9'(j_q));
  assign cz = $signed(9'(k_q));
  assign dx = cx - vgbse_pkg::sx9(job_i.x_lo);
  assign dy = cy - vgbse_pkg::sx9(job_i.y_lo);
  assign dz = cz - vgbse_pkg::sx9(job_i.z_lo);
  assign px = dx * dx;
  assign py = dy * dy;
  assign pz = dz * dz;

  assign in_box = (cx >= vgbse_pkg::sx9(job_i.x_lo)) && (cx <= vgbse_pkg::sx9(job_i.x_hi)) &&
                  (cy >= vgbse_pkg::sx9(job_i.y_lo)) && (cy <= vgbse_pkg::sx9(job_i.y_hi)) &&
                  (cz >= vgbse_pkg::sx9(job_i.z_lo)) && (cz <= vgbse_pkg::sx9(job_i.z_hi));

  always_ff @(posedge clk_i) begin
    s1_addr_q <= {i_q, j_q, k_q};
    s1_box_q  <= in_box;
    sq_x_q    <= px[vgbse_pkg::RadSqW-1:0];
    sq_y_q    <= py[vgbse_pkg::RadSqW-1:0];
    sq_z_q    <= pz[vgbse_pkg::RadSqW-1:0];
  end

  // stage 2: sum and radius compare, drives the store write
  assign dist_sq = vgbse_pkg::SumW'(sq_x_q) + vgbse_pkg::SumW'(sq_y_q) +
                   vgbse_pkg::SumW'(sq_z_q);
  assign hit     = job_i.sphere ? (dist_sq <= vgbse_pkg::SumW'(job_i.rad_sq)) : s1_box_q;

  assign addr_o       = s1_addr_q;
  assign stat_o.wr_en = s1_valid_q & hit;
  assign stat_o.done  = s1_valid_q & ~run_q;

endmodule

// ===== rtl/core/voxel_grid_box_sphere_editor_top.sv =====
// voxel grid editor: a 3-d grid of voxels, each an on flag plus 8-bit rgba color
// input channel: in_valid_i / in_ready_o with one command per transfer (point set or
//   clear, box set or clear, sphere set or clear, point read)
// output channel: out_valid_o / out_ready_i, exactly one result per command; reads
//   inside the grid return the voxel, every other command returns all zeros
// config port: cfg_we_i writes register cfg_idx_i at once; the user must write it only
//   while the block is idle, the block itself does not enforce this
// one command at a time; the store sits in two single-port-write memories (on flags,
//   colors) with a registered read
// point commands and reads: the point state writes or reads an in-range voxel, then the
//   result state loads the output register; the next input transfer waits for idle
// box and sphere commands: the sweep unit walks the nx*ny*nz voxels in use, one voxel
//   per cycle, where nx, ny, nz are the sizes in use clipped to MAX_EXTENT; the next
//   input transfer waits until the result is loaded into the output register
// a result waiting in the output register does not block the next input transfer;
//   a command that finishes while the receiver stalls holds in its result state
// reset: after rst_ni rises the store is cleared one entry per cycle; in_ready_o stays
//   low during that pass, config writes are taken as usual
`include "voxel_grid_box_sphere_editor_top_assert.svh"

module voxel_grid_box_sphere_editor_top #(
  parameter int unsigned MAX_EXTENT = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  vgbse_pkg::in_item_t                in_item_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output vgbse_pkg::out_item_t               out_item_o,
  input  logic                               cfg_we_i,
  input  logic [vgbse_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [vgbse_pkg::CfgDataW-1:0]     cfg_data_i
);

  localparam int unsigned CW    = $clog2(MAX_EXTENT);
  localparam int unsigned AW    = 3 * CW;
  localparam int unsigned Depth = 1 << AW;
  localparam int unsigned EW    = $clog2(MAX_EXTENT + 1);

  // configuration registers
  logic [vgbse_pkg::SizeW-1:0] size_x_q, size_y_q, size_z_q;
  logic [vgbse_pkg::ChanW-1:0] paint_r_q, paint_g_q, paint_b_q, paint_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q  <= vgbse_pkg::SizeW'(16);
      size_y_q  <= vgbse_pkg::SizeW'(16);
      size_z_q  <= vgbse_pkg::SizeW'(16);
      paint_r_q <= '0;
      paint_g_q <= '0;
      paint_b_q <= '0;
      paint_a_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        vgbse_pkg::CFG_SIZE_X:  size_x_q  <= cfg_data_i[vgbse_pkg::SizeW-1:0];
        vgbse_pkg::CFG_SIZE_Y:  size_y_q  <= cfg_data_i[vgbse_pkg::SizeW-1:0];
        vgbse_pkg::CFG_SIZE_Z:  size_z_q  <= cfg_data_i[vgbse_pkg::SizeW-1:0];
        vgbse_pkg::CFG_PAINT_R: paint_r_q <= cfg_data_i;
        vgbse_pkg::CFG_PAINT_G: paint_g_q <= cfg_data_i;
        vgbse_pkg::CFG_PAINT_B: paint_b_q <= cfg_data_i;
        vgbse_pkg::CFG_PAINT_A: paint_a_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sizes in use, saturated to the physical grid
  logic [EW-1:0] ext_x, ext_y, ext_z;
  logic          grid_empty;

  assign ext_x = (32'(size_x_q) > MAX_EXTENT) ? EW'(MAX_EXTENT) : EW'(size_x_q);
  assign ext_y = (32'(size_y_q) > MAX_EXTENT) ? EW'(MAX_EXTENT) : EW'(size_y_q);
  assign ext_z = (32'(size_z_q) > MAX_EXTENT) ? EW'(MAX_EXTENT) : EW'(size_z_q);
  assign grid_empty = (ext_x == '0) || (ext_y == '0) || (ext_z == '0);

  // command capture
  vgbse_pkg::state_e     state_q, state_d;
  logic                  in_xfer;
  logic                  in_inside;
  logic                  sweep_kind;
  logic [2:0]            kind_q;
  logic                  set_q;
  logic                  inside_q;
  logic [AW-1:0]         pt_addr_q;
  vgbse_pkg::sweep_job_t job_q;

  assign in_ready_o = (state_q == vgbse_pkg::ST_IDLE);
  assign in_xfer    = in_valid_i & in_ready_o;

  // bounds check of the single-voxel position
  assign in_inside =
    !in_item_i.x_lo[7] && (32'(in_item_i.x_lo[6:0]) < 32'(ext_x)) &&
    !in_item_i.y_lo[7] && (32'(in_item_i.y_lo[6:0]) < 32'(ext_y)) &&
    !in_item_i.z_lo[7] && (32'(in_item_i.z_lo[6:0]) < 32'(ext_z));

  assign sweep_kind = in_item_i.kind inside {vgbse_pkg::KIND_SET_BOX, vgbse_pkg::KIND_CLR_BOX,
                                             vgbse_pkg::KIND_SET_SPHERE,
                                             vgbse_pkg::KIND_CLR_SPHERE};

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      kind_q        <= in_item_i.kind;
      // set kinds are the even codes
      set_q         <= ~in_item_i.kind[0];
      inside_q      <= in_inside;
      pt_addr_q     <= {in_item_i.x_lo[CW-1:0], in_item_i.y_lo[CW-1:0],
                        in_item_i.z_lo[CW-1:0]};
      job_q.sphere  <= in_item_i.kind[2];
      job_q.x_lo    <= in_item_i.x_lo;
      job_q.x_hi    <= in_item_i.x_hi;
      job_q.y_lo    <= in_item_i.y_lo;
      job_q.y_hi    <= in_item_i.y_hi;
      job_q.z_lo    <= in_item_i.z_lo;
      job_q.z_hi    <= in_item_i.z_hi;
      job_q.rad_sq  <= vgbse_pkg::RadSqW'(in_item_i.radius) *
                       vgbse_pkg::RadSqW'(in_item_i.radius);
    end
  end

  // sweep unit walks the grid in use for box and sphere commands
  logic                   sweep_start;
  logic [AW-1:0]          sweep_addr;
  vgbse_pkg::sweep_stat_t sweep_stat;

  assign sweep_start = in_xfer & sweep_kind & ~grid_empty;

  vgbse_sweep #(
    .CW (CW),
    .EW (EW)
  ) u_sweep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sweep_start),
    .job_i   (job_q),
    .ext_x_i (ext_x),
    .ext_y_i (ext_y),
    .ext_z_i (ext_z),
    .addr_o  (sweep_addr),
    .stat_o  (sweep_stat)
  );

  // clearing pass counter
  logic [AW-1:0] clr_q, clr_d;

  // store write and read ports
  logic                       on_we, col_we, rd_en;
  logic [AW-1:0]              wr_addr;
  logic                       wr_on;
  logic [vgbse_pkg::ColW-1:0] wr_col;
  logic                       rd_on;
  logic [vgbse_pkg::ColW-1:0] rd_col;
  logic                       point_wr, point_rd;

  assign point_wr = inside_q && (kind_q == vgbse_pkg::KIND_SET_VOXEL ||
                                 kind_q == vgbse_pkg::KIND_CLR_VOXEL);
  assign point_rd = inside_q && (kind_q == vgbse_pkg::KIND_READ_VOXEL);

  // output register
  logic                 out_valid_q, out_valid_d;
  vgbse_pkg::out_item_t out_q, out_d;
  logic                 res_load;

  assign res_load = (state_q == vgbse_pkg::ST_RESULT) && (!out_valid_q || out_ready_i);

  // control: next state and store port drive
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    on_we   = 1'b0;
    col_we  = 1'b0;
    rd_en   = 1'b0;
    wr_addr = pt_addr_q;
    // a clear only drops the on flag, the color memory keeps its entry
    wr_on   = set_q;
    wr_col  = {paint_r_q, paint_g_q, paint_b_q, paint_a_q};
    case (state_q)
      vgbse_pkg::ST_CLEAR: begin
        on_we   = 1'b1;
        col_we  = 1'b1;
        wr_addr = clr_q;
        wr_on   = 1'b0;
        wr_col  = '0;
        clr_d   = clr_q + AW'(1);
        if (clr_q == '1) begin
          state_d = vgbse_pkg::ST_IDLE;
        end
      end
      vgbse_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (sweep_kind) begin
            state_d = grid_empty ? vgbse_pkg::ST_RESULT : vgbse_pkg::ST_SWEEP;
          end else begin
            state_d = vgbse_pkg::ST_POINT;
          end
        end
      end
      vgbse_pkg::ST_POINT: begin
        on_we   = point_wr;
        col_we  = point_wr & set_q;
        rd_en   = point_rd;
        state_d = vgbse_pkg::ST_RESULT;
      end
      vgbse_pkg::ST_SWEEP: begin
        on_we   = sweep_stat.wr_en;
        col_we  = sweep_stat.wr_en & set_q;
        wr_addr = sweep_addr;
        if (sweep_stat.done) begin
          state_d = vgbse_pkg::ST_RESULT;
        end
      end
      vgbse_pkg::ST_RESULT: begin
        if (res_load) begin
          state_d = vgbse_pkg::ST_IDLE;
        end
      end
      default: state_d = vgbse_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vgbse_pkg::ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  vgbse_ram #(
    .Width (1),
    .Depth (Depth)
  ) u_on_ram (
    .clk_i   (clk_i),
    .we_i    (on_we),
    .waddr_i (wr_addr),
    .wdata_i (wr_on),
    .re_i    (rd_en),
    .raddr_i (pt_addr_q),
    .rdata_o (rd_on)
  );

  vgbse_ram #(
    .Width (vgbse_pkg::ColW),
    .Depth (Depth)
  ) u_col_ram (
    .clk_i   (clk_i),
    .we_i    (col_we),
    .waddr_i (wr_addr),
    .wdata_i (wr_col),
    .re_i    (rd_en),
    .raddr_i (pt_addr_q),
    .rdata_o (rd_col)
  );

  // result: read data for an in-range read, zeros for everything else;
  // the read data register holds until the next read, so a stalled result is safe
  always_comb begin
    out_d = '0;
    if (point_rd) begin
      out_d.voxel_on    = rd_on;
      out_d.voxel_red   = rd_col[4*vgbse_pkg::ChanW-1:3*vgbse_pkg::ChanW];
      out_d.voxel_green = rd_col[3*vgbse_pkg::ChanW-1:2*vgbse_pkg::ChanW];
      out_d.voxel_blue  = rd_col[2*vgbse_pkg::ChanW-1:vgbse_pkg::ChanW];
      out_d.voxel_alpha = rd_col[vgbse_pkg::ChanW-1:0];
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // no store writes while waiting for a command or holding a result
  `VGBSE_ASSERT_IMP(a_no_idle_write,
                    state_q == vgbse_pkg::ST_IDLE || state_q == vgbse_pkg::ST_RESULT,
                    !on_we && !col_we)
  // a color write always comes with an on flag write
  `VGBSE_ASSERT_IMP(a_col_with_on, col_we, on_we)
  // the sweep only finishes while the controller waits for it
  `VGBSE_ASSERT_IMP(a_sweep_done_state, sweep_stat.done, state_q == vgbse_pkg::ST_SWEEP)
  // commands other than a read give an all-zero result
  `VGBSE_ASSERT_NXT(a_nonread_zero, res_load && kind_q != vgbse_pkg::KIND_READ_VOXEL,
                    out_q == '0)

endmodule

// ===== verif/voxel_grid_checker.sv =====
module voxel_grid_checker
  import vgbse_pkg::*;
#(
  parameter int MAX_EXTENT = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  in_item_t            in_item_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  out_item_t           out_item_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int unsigned         fail_cnt_o,
  output int unsigned         pending_o
);

  localparam int NumCells = MAX_EXTENT * MAX_EXTENT * MAX_EXTENT;

  // mirror of the voxel store and the registers
  logic              grid_on   [NumCells];
  logic [ColW-1:0]   grid_rgba [NumCells];
  logic [SizeW-1:0]  size_x_q, size_y_q, size_z_q;
  logic [ChanW-1:0]  paint_r_q, paint_g_q, paint_b_q, paint_a_q;

  out_item_t   read_back_q [$];
  int unsigned n_fail = 0;
  int unsigned n_pending = 0;

  assign fail_cnt_o = n_fail;
  assign pending_o  = n_pending;

  function automatic int clip_extent(logic [SizeW-1:0] s);
    return (s > MAX_EXTENT) ? MAX_EXTENT : int'(s);
  endfunction

  function automatic int cell_at(int x, int y, int z);
    return x + MAX_EXTENT * (y + MAX_EXTENT * z);
  endfunction

  task automatic paint_voxel(input int x, input int y, input int z, input bit set);
    int n;
    n = cell_at(x, y, z);
    if (set) begin
      grid_on[n]   = 1'b1;
      grid_rgba[n] = {paint_r_q, paint_g_q, paint_b_q, paint_a_q};
    end else begin
      grid_on[n] = 1'b0;
    end
  endtask

  // applies one command to the mirror and works out its result
  task automatic sculpt_grid(input in_item_t cmd, output out_item_t res);
    int nx, ny, nz, xl, xh, yl, yh, zl, zh, r2, dx, dy, dz;
    bit point_ok, sphere, set, hit;
    res = '0;
    nx = clip_extent(size_x_q);
    ny = clip_extent(size_y_q);
    nz = clip_extent(size_z_q);
    xl = $signed(cmd.x_lo);
    xh = $signed(cmd.x_hi);
    yl = $signed(cmd.y_lo);
    yh = $signed(cmd.y_hi);
    zl = $signed(cmd.z_lo);
    zh = $signed(cmd.z_hi);
    r2 = int'(cmd.radius) * int'(cmd.radius);
    point_ok = xl >= 0 && xl < nx && yl >= 0 && yl < ny && zl >= 0 && zl < nz;
    sphere = cmd.kind == KIND_SET_SPHERE || cmd.kind == KIND_CLR_SPHERE;
    set = cmd.kind == KIND_SET_BOX || cmd.kind == KIND_SET_SPHERE;
    case (cmd.kind)
      KIND_SET_VOXEL, KIND_CLR_VOXEL: begin
        if (point_ok) paint_voxel(xl, yl, zl, cmd.kind == KIND_SET_VOXEL);
      end
      KIND_SET_BOX, KIND_CLR_BOX, KIND_SET_SPHERE, KIND_CLR_SPHERE: begin
        for (int k = 0; k < nz; k++) begin
          for (int j = 0; j < ny; j++) begin
            for (int i = 0; i < nx; i++) begin
              if (sphere) begin
                dx = i - xl;
                dy = j - yl;
                dz = k - zl;
                hit = dx * dx + dy * dy + dz * dz <= r2;
              end else begin
                hit = i >= xl && i <= xh && j >= yl && j <= yh && k >= zl && k <= zh;
              end
              if (hit) paint_voxel(i, j, k, set);
            end
          end
        end
      end
      KIND_READ_VOXEL: begin
        if (point_ok) begin
          res.voxel_on = grid_on[cell_at(xl, yl, zl)];
          {res.voxel_red, res.voxel_green, res.voxel_blue, res.voxel_alpha} =
            grid_rgba[cell_at(xl, yl, zl)];
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string label, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      n_fail++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      for (int n = 0; n < NumCells; n++) begin
        grid_on[n]   = 1'b0;
        grid_rgba[n] = '0;
      end
      size_x_q  = 5'd16;
      size_y_q  = 5'd16;
      size_z_q  = 5'd16;
      paint_r_q = '0;
      paint_g_q = '0;
      paint_b_q = '0;
      paint_a_q = '0;
      read_back_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (read_back_q.size() == 0) begin
          n_fail++;
          $display("%0t: result with no command outstanding, expected none, actual %h",
                   $time, out_item_i);
        end else begin
          want = read_back_q.pop_front();
          check_field("voxel_on", want.voxel_on, out_item_i.voxel_on);
          check_field("voxel_red", want.voxel_red, out_item_i.voxel_red);
          check_field("voxel_green", want.voxel_green, out_item_i.voxel_green);
          check_field("voxel_blue", want.voxel_blue, out_item_i.voxel_blue);
          check_field("voxel_alpha", want.voxel_alpha, out_item_i.voxel_alpha);
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SIZE_X:  size_x_q  = cfg_data_i[SizeW-1:0];
          CFG_SIZE_Y:  size_y_q  = cfg_data_i[SizeW-1:0];
          CFG_SIZE_Z:  size_z_q  = cfg_data_i[SizeW-1:0];
          CFG_PAINT_R: paint_r_q = cfg_data_i;
          CFG_PAINT_G: paint_g_q = cfg_data_i;
          CFG_PAINT_B: paint_b_q = cfg_data_i;
          CFG_PAINT_A: paint_a_q = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        sculpt_grid(in_item_i, want);
        read_back_q.push_back(want);
      end
    end
    n_pending = read_back_q.size();
  end

endmodule

// ===== verif/tb_voxel_grid_box_sphere_editor_top.sv =====
module tb_voxel_grid_box_sphere_editor_top;
  import vgbse_pkg::*;

  localparam int MaxExtent  = 16;
  // the worst correct run stays well below this limit, which leaves plenty of slack
  localparam int CycleLimit = 1_000_000;
  // register index past the end of the list, must be ignored
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 3'd7;
  // unused command code, must change nothing and return zeros
  localparam logic [2:0] KindSpare = 3'd7;

  // every input starts at a known value
  logic                clk_i      = 1'b0;
  logic                rst_ni     = 1'b0;
  logic                in_valid_i = 1'b0;
  in_item_t            in_item_i  = '0;
  logic                out_ready_i = 1'b0;
  logic                cfg_we_i   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i  = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_ready_o;
  logic                out_valid_o;
  out_item_t           out_item_o;

  int unsigned fail_cnt;
  int unsigned pending_cnt;
  int          cycle_cnt    = 0;
  // chance in percent of a sender gap and of a receiver stall per cycle
  int          send_gap_pct = 0;
  int          stall_pct    = 0;
  // grid extent in use, for aiming coordinates at the grid
  int          span_x = MaxExtent;
  int          span_y = MaxExtent;
  int          span_z = MaxExtent;

  voxel_grid_box_sphere_editor_top #(
    .MAX_EXTENT(MaxExtent)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  // watches all three ports, mirrors the grid and compares every result transfer
  voxel_grid_checker #(
    .MAX_EXTENT(MaxExtent)
  ) u_grid_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_i  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending_cnt)
  );

  // 8 time unit clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  // receiver side: ready drawn fresh every cycle, stall chance set per phase
  always @(negedge clk_i) out_ready_i <= ($urandom_range(99) >= stall_pct);

  // watchdog
  initial begin
    wait (cycle_cnt >= CycleLimit);
    $display("TB_ERROR");
    $finish;
  end

  // one command transfer; valid holds with a steady payload until taken
  task automatic issue_cmd(input in_item_t cmd);
    @(negedge clk_i);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= cmd;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // drop valid and wait for every outstanding result, then a short margin
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_cnt != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
  endtask

  // size writes carry random junk in the bits above the 5-bit field
  task automatic program_regs(input int sx, input int sy, input int sz,
                              input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b, input logic [7:0] a);
    write_reg(CFG_SIZE_X, {3'($urandom), 5'(sx)});
    write_reg(CFG_SIZE_Y, {3'($urandom), 5'(sy)});
    write_reg(CFG_SIZE_Z, {3'($urandom), 5'(sz)});
    write_reg(CFG_PAINT_R, r);
    write_reg(CFG_PAINT_G, g);
    write_reg(CFG_PAINT_B, b);
    write_reg(CFG_PAINT_A, a);
    write_reg(CfgIdxSpare, 8'($urandom));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    span_x = (sx > MaxExtent) ? MaxExtent : sx;
    span_y = (sy > MaxExtent) ? MaxExtent : sy;
    span_z = (sz > MaxExtent) ? MaxExtent : sz;
  endtask

  function automatic in_item_t mk_cmd(input logic [2:0] kind, input int xl, input int xh,
                                      input int yl, input int yh, input int zl,
                                      input int zh, input int rad);
    in_item_t cmd;
    cmd.kind   = kind;
    cmd.x_lo   = 8'(xl);
    cmd.x_hi   = 8'(xh);
    cmd.y_lo   = 8'(yl);
    cmd.y_hi   = 8'(yh);
    cmd.z_lo   = 8'(zl);
    cmd.z_hi   = 8'(zh);
    cmd.radius = 8'(rad);
    return cmd;
  endfunction

  // mostly just around the grid so edits and reads overlap, now and then anywhere
  function automatic logic signed [7:0] pick_coord(input int span);
    if ($urandom_range(99) < 15) return 8'($urandom);
    return 8'(int'($urandom_range(span + 5)) - 3);
  endfunction

  function automatic in_item_t random_cmd();
    in_item_t cmd;
    int       roll;
    bit       sphere;
    roll = $urandom_range(99);
    if (roll < 30)      cmd.kind = KIND_READ_VOXEL;
    else if (roll < 50) cmd.kind = KIND_SET_VOXEL;
    else if (roll < 58) cmd.kind = KIND_CLR_VOXEL;
    else if (roll < 70) cmd.kind = KIND_SET_BOX;
    else if (roll < 78) cmd.kind = KIND_CLR_BOX;
    else if (roll < 88) cmd.kind = KIND_SET_SPHERE;
    else if (roll < 95) cmd.kind = KIND_CLR_SPHERE;
    else                cmd.kind = KindSpare;
    sphere = cmd.kind == KIND_SET_SPHERE || cmd.kind == KIND_CLR_SPHERE;
    cmd.x_lo = pick_coord(span_x);
    cmd.y_lo = pick_coord(span_y);
    cmd.z_lo = pick_coord(span_z);
    // boxes are usually small, sometimes arbitrary (and then often empty)
    cmd.x_hi = ($urandom_range(9) == 0) ? 8'($urandom) : cmd.x_lo + 8'($urandom_range(4));
    cmd.y_hi = ($urandom_range(9) == 0) ? 8'($urandom) : cmd.y_lo + 8'($urandom_range(4));
    cmd.z_hi = ($urandom_range(9) == 0) ? 8'($urandom) : cmd.z_lo + 8'($urandom_range(4));
    cmd.radius = (!sphere || $urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(6));
    return cmd;
  endfunction

  initial begin
    int n_items;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // registers may be written during the clearing pass after reset
    program_regs(16, 16, 16, 8'hFF, 8'h00, 8'hA5, 8'h5A);

    // directed part on the full grid, no idling
    issue_cmd(mk_cmd(KIND_READ_VOXEL, 0, 0, 0, 0, 0, 0, 0));         // cleared by reset
    issue_cmd(mk_cmd(KIND_SET_VOXEL, 0, 0, 0, 0, 0, 0, 0));
    issue_cmd(mk_cmd(KIND_READ_VOXEL, 0, 0, 0, 0, 0, 0, 0));
    issue_cmd(mk_cmd(KIND_SET_VOXEL, 15, 0, 15, 0, 15, 0, 255));     // far corner
    issue_cmd(mk_cmd(KIND_READ_VOXEL, 15, 0, 15, 0, 15, 0, 0));
    issue_cmd(mk_cmd(KIND_SET_VOXEL, 16, 0, 3, 0, 3, 0, 0));         // just outside
    issue_cmd(mk_cmd(KIND_READ_VOXEL, 16, 0, 3, 0, 3, 0, 0));
    issue_cmd(mk_cmd(KIND_READ_VOXEL, -1, -1, 0, -1, 0, -1, 0));     // negative position
    issue_cmd(mk_cmd(KIND_CLR_VOXEL, 0, 0, 0, 0, 0, 0, 0));
    issue_cmd(mk_cmd(KIND_READ_VOXEL, 0, 0, 0, 0, 0, 0, 0));         // off, color kept
    issue_cmd(mk_cmd(KIND_SET_BOX, -128, 127, -128, 127, -128, 127, 0)); // clipped to grid
    issue_cmd(mk_cmd(KIND_READ_VOXEL, 7, 0, 8, 0, 9, 0, 0));
    issue_cmd(mk_cmd(KIND_CLR_BOX, 5, 4, 0, 15, 0, 15, 0));          // lower above upper
    issue_cmd(mk_cmd(KIND_READ_VOXEL, 5, 0, 5, 0, 5, 0, 0));
    issue_cmd(mk_cmd(KIND_CLR_BOX, -5, 3, 10, 127, 2, 2, 0));        // partly outside
    issue_cmd(mk_cmd(KIND_READ_VOXEL, 3, 0, 12, 0, 2, 0, 0));
    // widest sphere from the far negative corner still covers the whole grid
    issue_cmd(mk_cmd(KIND_CLR_SPHERE, -128, 0, -128, 0, -128, 0, 255));
    issue_cmd(mk_cmd(KIND_READ_VOXEL, 15, 0, 15, 0, 15, 0, 0));
    issue_cmd(mk_cmd(KIND_SET_SPHERE, 14, 0, 1, 0, 8, 0, 3));        // crosses the edge
    issue_cmd(mk_cmd(KIND_READ_VOXEL, 15, 0, 1, 0, 8, 0, 0));
    issue_cmd(mk_cmd(KIND_SET_SPHERE, 5, 0, 5, 0, 5, 0, 0));         // zero radius
    issue_cmd(mk_cmd(KIND_READ_VOXEL, 5, 0, 5, 0, 5, 0, 0));
    issue_cmd(mk_cmd(KindSpare, 127, 127, 127, 127, 127, 127, 255));
    issue_cmd(mk_cmd(KIND_CLR_VOXEL, 127, -128, 127, -128, 127, -128, 128));
    settle();

    // random phases: registers change only between phases while the block is idle
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin
          // zero-size grid, nothing may change and reads give zeros
          program_regs(0, 5, 3, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
          n_items = 8;
        end
        1: begin
          // oversized x saturates to the full extent
          program_regs(31, 1, 2, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
          n_items = 16;
        end
        2: begin
          program_regs(1, 1, 1, 8'h00, 8'h00, 8'h00, 8'h00);
          n_items = 12;
        end
        7: begin
          // grow back to full size, earlier contents beyond small grids show again
          program_regs(16, 16, 16, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
          n_items = 12;
        end
        default: begin
          // small grids keep sweeps short
          program_regs($urandom_range(6, 1), $urandom_range(6, 1), $urandom_range(6, 1),
                       8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
          n_items = 17;
        end
      endcase
      // rotate through the idling patterns
      case (p % 4)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 49; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 49; end
        default: begin send_gap_pct = 32; stall_pct = 32; end
      endcase
      repeat (n_items) issue_cmd(random_cmd());
      settle();
    end

    // margin for any stray result after the last one expected
    repeat (16) @(negedge clk_i);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/vgbse_pkg.sv
rtl/core/vgbse_ram.sv
rtl/core/vgbse_sweep.sv
rtl/core/voxel_grid_box_sphere_editor_top.sv
verif/voxel_grid_checker.sv
verif/tb_voxel_grid_box_sphere_editor_top.sv
